@@ rtl/dht_pkg.sv @@
package dht_pkg;

    // Table geometry defaults
    localparam int TABLE_SIZE_DEF = 1021;
    localparam int STEP_PRIME_DEF = 17;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int PROBES_W = 10;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Operation codes
    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_SEARCH = 1'b1
    } t_func;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_STEP,
        S_READ,
        S_CHECK,
        S_EMIT
    } t_state;

endpackage

@@ rtl/double_hash_table_core.sv @@
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: func; tdata: key, value
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: status, probes
//
// After reset the table sweeps all TABLE_SIZE slots, one per cycle, to clear
// the occupied bits; no item is taken during that sweep.
// Each item is hashed by one shared compare-subtract remainder unit that forms
// both hashes one key bit per cycle, then reduces the step; each probe is a
// read and a check of the slot memory. Results wait in an output register, so
// a stalled m_axis only holds the finished result, and the next item may enter
// meanwhile.
module double_hash_table_core
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int STEP_PRIME = STEP_PRIME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] value
    input  logic        s_axis_tuser,  // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [2:0] status, [12:3] probes, [15:13] zero
);

    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int PW    = $clog2(TABLE_SIZE + 1);
    localparam int SPW   = (STEP_PRIME > 2) ? $clog2(STEP_PRIME) : 1;
    localparam int SW    = $clog2(STEP_PRIME + 1);
    localparam int CNT_W = $clog2(KEY_W);
    localparam int ENT_W = 1 + KEY_W + VALUE_W;

    // Slot memory: {occupied, value, key}
    logic [ENT_W-1:0] r_mem [TABLE_SIZE];
    logic [ENT_W-1:0] r_rd;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VALUE_W-1:0] r_value, n_value;
    t_func              r_func, n_func;
    logic [AW-1:0]      r_rem_ts, n_rem_ts;
    logic [SPW-1:0]     r_rem_sp, n_rem_sp;
    logic [SW-1:0]      r_step_raw, n_step_raw;
    logic [AW-1:0]      r_step, n_step;
    logic [AW-1:0]      r_first, n_first;
    logic [AW-1:0]      r_slot, n_slot;
    logic [PW-1:0]      r_probes, n_probes;
    t_status            r_status, n_status;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [PW-1:0]      r_out_probes, n_out_probes;

    logic               w_en;
    logic [AW-1:0]      w_addr;
    logic [ENT_W-1:0]   w_data;

    // Shared remainder unit signals
    logic               feed_bit;
    logic [AW:0]        sh_ts;
    logic [AW-1:0]      red_ts;
    logic [SPW:0]       sh_sp;
    logic [SPW-1:0]     red_sp;

    // Probe check signals
    logic               ent_occ;
    logic [KEY_W-1:0]   ent_key;
    logic [VALUE_W-1:0] ent_value;
    logic [AW:0]        slot_sum;
    logic [AW-1:0]      slot_next;
    logic [PW-1:0]      probes_inc;

    assign ent_occ   = r_rd[ENT_W-1];
    assign ent_value = r_rd[KEY_W +: VALUE_W];
    assign ent_key   = r_rd[KEY_W-1:0];

    // Shift one bit into each remainder and subtract the divisor when reached
    always_comb begin
        sh_ts  = {r_rem_ts, feed_bit};
        red_ts = (sh_ts >= (AW+1)'(TABLE_SIZE)) ? AW'(sh_ts - (AW+1)'(TABLE_SIZE))
                                                : sh_ts[AW-1:0];
        sh_sp  = {r_rem_sp, feed_bit};
        red_sp = (sh_sp >= (SPW+1)'(STEP_PRIME)) ? SPW'(sh_sp - (SPW+1)'(STEP_PRIME))
                                                 : sh_sp[SPW-1:0];
    end

    // Advance the slot by the reduced step, wrapping at the table size
    always_comb begin
        slot_sum   = {1'b0, r_slot} + {1'b0, r_step};
        slot_next  = (slot_sum >= (AW+1)'(TABLE_SIZE)) ?
                     AW'(slot_sum - (AW+1)'(TABLE_SIZE)) : slot_sum[AW-1:0];
        probes_inc = r_probes + PW'(1);
    end

    // Hold the memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[r_slot];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_key        <= n_key;
        r_value      <= n_value;
        r_func       <= n_func;
        r_rem_ts     <= n_rem_ts;
        r_rem_sp     <= n_rem_sp;
        r_step_raw   <= n_step_raw;
        r_step       <= n_step;
        r_first      <= n_first;
        r_slot       <= n_slot;
        r_probes     <= n_probes;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_probes <= n_out_probes;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cnt        = r_cnt;
        n_key        = r_key;
        n_value      = r_value;
        n_func       = r_func;
        n_rem_ts     = r_rem_ts;
        n_rem_sp     = r_rem_sp;
        n_step_raw   = r_step_raw;
        n_step       = r_step;
        n_first      = r_first;
        n_slot       = r_slot;
        n_probes     = r_probes;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_probes = r_out_probes;
        w_en         = 1'b0;
        w_addr       = r_slot;
        w_data       = {1'b1, r_value, r_key};
        feed_bit     = 1'b0;
        s_axis_tready = 1'b0;

        // Drop the result once taken
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_en   = 1'b1;
                w_addr = r_clr;
                w_data = '0;
                n_clr  = r_clr + AW'(1);
                if (r_clr == AW'(TABLE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_key    = s_axis_tdata[KEY_W-1:0];
                    n_value  = s_axis_tdata[KEY_W +: VALUE_W];
                    n_func   = t_func'(s_axis_tuser);
                    n_rem_ts = '0;
                    n_rem_sp = '0;
                    n_probes = '0;
                    n_cnt    = CNT_W'(KEY_W - 1);
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                // Form key mod table size and key mod step prime, MSB first
                feed_bit = r_key[r_cnt];
                n_rem_ts = red_ts;
                n_rem_sp = red_sp;
                n_cnt    = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_first    = red_ts;
                    n_slot     = red_ts;
                    n_step_raw = SW'(STEP_PRIME) - SW'(red_sp);
                    n_rem_ts   = '0;
                    n_cnt      = CNT_W'(SW - 1);
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                // Reduce the step mod table size
                feed_bit = r_step_raw[r_cnt[$clog2(SW)-1:0]];
                n_rem_ts = red_ts;
                n_cnt    = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_step  = red_ts;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_probes = probes_inc;
                priority if (!ent_occ) begin
                    if (r_func == FN_INSERT) begin
                        w_en     = 1'b1;
                        n_status = ST_INSERTED;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                    n_state = S_EMIT;
                end else if (ent_key == r_key && r_func == FN_INSERT) begin
                    w_en     = 1'b1;
                    n_status = ST_UPDATED;
                    n_state  = S_EMIT;
                end else if (ent_key == r_key && ent_value == r_value) begin
                    n_status = ST_FOUND;
                    n_state  = S_EMIT;
                end else if (slot_next == r_first || probes_inc >= PW'(TABLE_SIZE)) begin
                    n_status = (r_func == FN_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    n_state  = S_EMIT;
                end else begin
                    n_slot  = slot_next;
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                // Load the output register when it is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_probes = r_probes;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, PROBES_W'(r_out_probes), r_out_status};

endmodule
